/* rtl/wildcard_byte_pattern_scanner_core_macros.svh */
// ----------------------------------------------------------------------------
// wildcard byte pattern scanner assertion macros
// concurrent assertion shorthands clocked on clk_i; WBPS_ASSERT is disabled by rst_ni
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_CORE_MACROS_SVH

// checked outside reset only
`define WBPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wbps assertion failed");

// checked on every edge, reset included
`define WBPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("wbps assertion failed");

`endif

/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// shared types and constants of the wildcard byte pattern scanner
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned LEN_CFG_W         = 7;
  localparam int unsigned RES_DEPTH         = 4;
  localparam logic [7:0]  WILDCARD_BYTE     = 8'h3F;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } op_e;

  typedef enum logic {
    KIND_MATCH  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_UNIQUE = 2'd1,
    STATUS_MULTI  = 2'd2
  } status_e;

  typedef struct packed {
    logic       op;
    logic [5:0] pattern_index;
    logic [7:0] pattern_value;
    logic [7:0] data_byte;
    logic       region_end;
  } scan_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] match_position;
    logic [1:0]  match_status;
    logic        last_result;
  } scan_out_t;

  typedef struct packed {
    logic [1:0] count;
    scan_out_t  first;
    scan_out_t  second;
  } res_push_t;

endpackage

`default_nettype wire

/* rtl/wbps_match.sv */
// ----------------------------------------------------------------------------
// wbps_match
// parallel compare of the aligned pattern against the byte window
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_match import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] pattern_i,
  input  logic [PATTERN_MAX-1:0][7:0] window_i,
  input  logic [LenW-1:0]             length_i,
  input  logic [LenW-1:0]             fill_i,
  output logic                        hit_o
);

  logic [PATTERN_MAX-1:0] ok;

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      ok[j] = (32'(j) >= 32'(length_i)) ||
              (pattern_i[j] == WILDCARD_BYTE) ||
              (pattern_i[j] == window_i[j]);
    end
  end

  assign hit_o = (fill_i >= length_i) && (&ok);

endmodule

`default_nettype wire

/* rtl/wbps_result_fifo.sv */
// ----------------------------------------------------------------------------
// wbps_result_fifo
// small result queue taking up to two results per cycle, one out per cycle unless out_stall_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_result_fifo import wbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output scan_out_t out_data_o
);

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = $clog2(RES_DEPTH + 1);

  scan_out_t [RES_DEPTH-1:0] mem_q;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(RES_DEPTH - 2));
  assign pop         = out_valid_o & ~out_stall_i;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wildcard_byte_pattern_scanner_core.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_core
// streaming wildcard byte pattern search with per-region match status
// ----------------------------------------------------------------------------
// channel  signals                                 role
// cfg      cfg_valid_i cfg_ready_o cfg_data_i      pattern length write
// in       in_valid_i  in_stall_o  in_data_i       pattern load or region byte
// out      out_valid_o out_stall_i out_data_o      match position or status
//
// one item per cycle unless in_stall_o is high: input register, one compare pass, result queue
// an item is held in the input register, compared, and its results written to the queue before they reach out
// a length write realigns the pattern copy by shifting it, with in_stall_o high and cfg_ready_o low
// reset clears control state only; stalls on out back up through the queue
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scanner_core import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LEN_CFG_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  scan_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output scan_out_t            out_data_o
);

  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  scan_in_t                    in_q;
  logic                        in_full_q, in_full_d;
  logic [PATTERN_MAX-1:0][7:0] pat_q, align_q, win_q, win_next;
  logic [LenW-1:0]             len_q, shift_q, fill_q, len_eff, fill_inc;
  logic [POSITION_BITS-1:0]    pos_q, start_pos;
  logic [1:0]                  mcnt_q, mcnt_inc;
  logic                        hit, room, busy, accept, consume;
  logic                        is_scan, is_load, load_ok, cfg_write;
  scan_out_t                   res_match, res_status;
  res_push_t                   push;

  assign busy        = (shift_q != '0);
  assign cfg_ready_o = ~busy;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = busy | (in_full_q & ~room);
  assign accept      = in_valid_i & ~in_stall_o;
  assign consume     = in_full_q & room & ~busy;
  assign is_scan     = consume & (in_q.op == OP_SCAN);
  assign is_load     = consume & (in_q.op == OP_LOAD);
  assign load_ok     = (32'(in_q.pattern_index) < PATTERN_MAX);
  assign in_full_d   = accept ? 1'b1 : (consume ? 1'b0 : in_full_q);

  always_comb begin
    if (cfg_data_i == '0) begin
      len_eff = LenW'(1);
    end else if (32'(cfg_data_i) > PATTERN_MAX) begin
      len_eff = LenW'(PATTERN_MAX);
    end else begin
      len_eff = LenW'(cfg_data_i);
    end
  end

  always_comb begin
    win_next[0] = in_q.data_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_next[j] = win_q[j-1];
    end
  end

  assign fill_inc = (fill_q < LenW'(PATTERN_MAX)) ? fill_q + LenW'(1) : fill_q;

  wbps_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .pattern_i(align_q),
    .window_i (win_next),
    .length_i (len_q),
    .fill_i   (fill_inc),
    .hit_o    (hit)
  );

  assign mcnt_inc  = (hit && (mcnt_q != 2'(STATUS_MULTI))) ? mcnt_q + 2'd1 : mcnt_q;
  assign start_pos = pos_q - POSITION_BITS'(len_q - LenW'(1));

  always_comb begin
    res_match.result_kind    = KIND_MATCH;
    res_match.match_position = 32'(start_pos);
    res_match.match_status   = STATUS_NONE;
    res_match.last_result    = ~in_q.region_end;

    res_status.result_kind    = KIND_STATUS;
    res_status.match_position = '0;
    res_status.match_status   = mcnt_inc;
    res_status.last_result    = 1'b1;

    push.count  = is_scan ? (2'(hit) + 2'(in_q.region_end)) : 2'd0;
    push.first  = hit ? res_match : res_status;
    push.second = res_status;
  end

  wbps_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (is_scan) begin
      win_q <= win_next;
    end
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (is_load && (32'(in_q.pattern_index) == k)) begin
        pat_q[k] <= in_q.pattern_value;
      end
    end
    // aligned copy: align_q[j] holds pattern entry length-1-j
    if (cfg_write) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        align_q[j] <= pat_q[PATTERN_MAX-1-j];
      end
    end else if (busy) begin
      for (int j = 0; j + 1 < PATTERN_MAX; j++) begin
        align_q[j] <= align_q[j+1];
      end
    end else if (is_load && load_ok) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (32'(j) + 32'(in_q.pattern_index) + 32'd1 == 32'(len_q)) begin
          align_q[j] <= in_q.pattern_value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      len_q     <= LenW'(1);
      shift_q   <= '0;
      fill_q    <= '0;
      pos_q     <= '0;
      mcnt_q    <= '0;
    end else begin
      in_full_q <= in_full_d;
      if (cfg_write) begin
        len_q   <= len_eff;
        shift_q <= LenW'(PATTERN_MAX) - len_eff;
      end else if (busy) begin
        shift_q <= shift_q - LenW'(1);
      end
      if (is_scan) begin
        if (in_q.region_end) begin
          fill_q <= '0;
          pos_q  <= '0;
          mcnt_q <= '0;
        end else begin
          fill_q <= fill_inc;
          pos_q  <= pos_q + POSITION_BITS'(1);
          mcnt_q <= mcnt_inc;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wbps_checker.sv */
// ----------------------------------------------------------------------------
// wbps_checker
// port level checks of the wildcard byte pattern scanner, bound to the core
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_byte_pattern_scanner_core_macros.svh"

module wbps_checker import wbps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cfg_ready_o,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input scan_out_t out_data_o
);

  `WBPS_ASSERT(a_out_valid_held, out_valid_o && out_stall_i |=> out_valid_o)
  `WBPS_ASSERT(a_out_data_held, out_valid_o && out_stall_i |=> $stable(out_data_o))
  `WBPS_ASSERT(a_status_shape, out_valid_o && (out_data_o.result_kind == KIND_STATUS) |-> out_data_o.last_result && (out_data_o.match_position == '0))
  `WBPS_ASSERT_ALWAYS(a_realign_stalls_in, !cfg_ready_o |-> in_stall_o)

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (.*);

`default_nettype wire
